/* hdl/rwh_pkg.sv */
// Shared types, constants and tag tables for the RIFF WAVE header parser.
package rwh_pkg;

  localparam int OFFSET_BITS    = 32;
  localparam int MIN_FILE_BYTES = 44;

  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN  = 32'd16;
  localparam logic [15:0] PCM_TAG  = 16'h0001;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_BAD_HEADER = 3'd1;
  localparam logic [2:0] STATUS_NO_FORMAT  = 3'd2;
  localparam logic [2:0] STATUS_NO_DATA    = 3'd3;
  localparam logic [2:0] STATUS_ZERO_FIELD = 3'd4;

  localparam int OPQ_DEPTH     = 4;
  localparam int OPQ_PTR_BITS  = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_BITS  = $clog2(OPQ_DEPTH + 1);
  localparam int RESQ_DEPTH    = 2;
  localparam int RESQ_PTR_BITS = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_BITS = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_FILE,
    PH_HEAD,
    PH_BODY,
    PH_PAD,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic        last;
    logic        hdr_bad;
    logic        short_file;
    logic        fmt_wr;
    logic [3:0]  fmt_idx;
    logic        clr_pend;
    logic        commit_fmt;
    logic        commit_data;
    logic [31:0] data_start;
    logic [31:0] data_len;
  } op_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] frame_align;
    logic [15:0] sample_bits;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } result_t;

  function automatic logic [7:0] riff_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h52;
      2'd1:    val = 8'h49;
      default: val = 8'h46;
    endcase
    return val;
  endfunction

  function automatic logic [7:0] wave_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h57;
      2'd1:    val = 8'h41;
      2'd2:    val = 8'h56;
      default: val = 8'h45;
    endcase
    return val;
  endfunction

endpackage

/* hdl/rwh_front.sv */
// Front end: tracks file offset and chunk framing and classifies each byte into an operation.
module rwh_front import rwh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] file_byte,
  input  logic       is_last,
  output op_t        op
);

  phase_t                 phase;
  phase_t                 phase_next;
  logic [OFFSET_BITS-1:0] pos;
  logic [2:0]             hdr_idx;
  logic [31:0]            tag;
  logic [31:0]            len;
  logic [31:0]            remain;
  logic [4:0]             body_idx;
  logic [31:0]            body_start;

  logic [31:0] tag_next;
  logic [31:0] len_next;
  logic [31:0] pos_inc;
  logic        pos_max;
  logic        head_done;
  logic        head_commit;
  logic        body_commit;

  assign pos_max   = &pos;
  assign pos_inc   = 32'(pos) + 32'd1;
  assign tag_next  = (phase == PH_HEAD && !hdr_idx[2]) ? {file_byte, tag[31:8]} : tag;
  assign len_next  = (phase == PH_HEAD && hdr_idx[2]) ? {file_byte, len[31:8]} : len;
  assign head_done = (phase == PH_HEAD) && (hdr_idx == 3'd7);
  assign head_commit = head_done && (len_next == 32'd0);
  assign body_commit = (phase == PH_BODY) && (remain == 32'd0);

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_FILE: begin
        if (pos >= OFFSET_BITS'(11)) begin
          phase_next = PH_HEAD;
        end
      end
      PH_HEAD: begin
        if (head_done && len_next != 32'd0) begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        if (body_commit) begin
          phase_next = len[0] ? PH_PAD : PH_HEAD;
        end
      end
      PH_PAD: begin
        phase_next = PH_HEAD;
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
    if (pos_max) begin
      phase_next = PH_HALT;
    end
  end

  always_comb begin
    op.byte_val   = file_byte;
    op.last       = is_last;
    op.hdr_bad    = (phase == PH_FILE) &&
                    ((pos < OFFSET_BITS'(4) && file_byte != riff_byte(pos[1:0])) ||
                     (pos >= OFFSET_BITS'(8) && pos < OFFSET_BITS'(12) &&
                      file_byte != wave_byte(pos[1:0])));
    op.short_file = pos < OFFSET_BITS'(MIN_FILE_BYTES - 1);
    op.fmt_wr     = (phase == PH_BODY) && (tag == TAG_FMT) && !body_idx[4];
    op.fmt_idx    = body_idx[3:0];
    op.clr_pend   = head_done;
    op.commit_fmt = body_commit && (tag == TAG_FMT) && (len >= FMT_MIN);
    op.commit_data = (head_commit && tag_next == TAG_DATA) ||
                     (body_commit && tag == TAG_DATA);
    op.data_start = head_commit ? pos_inc : body_start;
    op.data_len   = head_commit ? 32'd0 : len;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && is_last)) begin
      phase    <= PH_FILE;
      pos      <= '0;
      hdr_idx  <= '0;
      body_idx <= '0;
    end else if (take) begin
      phase <= phase_next;
      if (!pos_max) begin
        pos <= pos + OFFSET_BITS'(1);
      end
      case (phase)
        PH_HEAD: begin
          tag     <= tag_next;
          len     <= len_next;
          hdr_idx <= hdr_idx + 3'd1;
          if (head_done) begin
            remain     <= len_next - 32'd1;
            body_idx   <= '0;
            body_start <= pos_inc;
          end
        end
        PH_BODY: begin
          remain <= remain - 32'd1;
          if (!body_idx[4]) begin
            body_idx <= body_idx + 5'd1;
          end
        end
        default: begin
          hdr_idx <= '0;
        end
      endcase
    end
  end

endmodule

/* hdl/rwh_op_queue.sv */
// Short queue of classified byte operations between the front and back ends.
module rwh_op_queue import rwh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  din,
  input  logic pop,
  output op_t  dout,
  output logic empty,
  output logic full
);

  op_t                     mem [OPQ_DEPTH];
  logic [OPQ_PTR_BITS-1:0] wptr;
  logic [OPQ_PTR_BITS-1:0] rptr;
  logic [OPQ_CNT_BITS-1:0] count;
  logic                    do_push;
  logic                    do_pop;

  assign empty   = (count == '0);
  assign full    = (count == OPQ_CNT_BITS'(OPQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == OPQ_PTR_BITS'(OPQ_DEPTH - 1)) ? '0 : wptr + OPQ_PTR_BITS'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == OPQ_PTR_BITS'(OPQ_DEPTH - 1)) ? '0 : rptr + OPQ_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + OPQ_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - OPQ_CNT_BITS'(1);
      end
    end
  end

endmodule

/* hdl/rwh_back.sv */
// Back end: collects format and data chunk fields, builds the status word and buffers results.
module rwh_back import rwh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  input  op_t     op,
  output logic    op_pop,
  input  logic    res_pop,
  output logic    res_empty,
  output result_t res
);

  logic         header_good;
  logic [127:0] pend;
  logic [127:0] saved;
  logic         format_good;
  logic         data_seen;
  logic [31:0]  data_start;
  logic [31:0]  data_bytes;

  logic         header_good_next;
  logic [127:0] pend_next;
  logic [127:0] saved_next;
  logic         format_good_next;
  logic         data_seen_next;
  logic [31:0]  data_start_next;
  logic [31:0]  data_bytes_next;
  result_t      res_new;

  result_t                  rbuf [RESQ_DEPTH];
  logic [RESQ_PTR_BITS-1:0] wptr;
  logic [RESQ_PTR_BITS-1:0] rptr;
  logic [RESQ_CNT_BITS-1:0] rcount;
  logic                     res_full;
  logic                     res_push;
  logic                     res_take;

  assign res_full  = (rcount == RESQ_CNT_BITS'(RESQ_DEPTH));
  assign res_empty = (rcount == '0);
  assign res_take  = res_pop && !res_empty;
  assign op_pop    = op_valid && !(op.last && res_full);
  assign res_push  = op_pop && op.last;
  assign res       = rbuf[rptr];

  always_comb begin
    header_good_next = header_good && !op.hdr_bad;
    pend_next        = op.clr_pend ? '0 : pend;
    if (op.fmt_wr) begin
      pend_next[{op.fmt_idx, 3'b000} +: 8] = op.byte_val;
    end
    saved_next       = saved;
    format_good_next = format_good;
    data_seen_next   = data_seen;
    data_start_next  = data_start;
    data_bytes_next  = data_bytes;
    if (op.commit_fmt) begin
      saved_next       = pend_next;
      format_good_next = (pend_next[15:0] == PCM_TAG);
    end
    if (op.commit_data) begin
      data_seen_next  = 1'b1;
      data_start_next = op.data_start;
      data_bytes_next = op.data_len;
    end
  end

  always_comb begin
    res_new.channel_count = saved_next[31:16];
    res_new.sample_rate   = saved_next[63:32];
    res_new.byte_rate     = saved_next[95:64];
    res_new.frame_align   = saved_next[111:96];
    res_new.sample_bits   = saved_next[127:112];
    res_new.data_offset   = data_start_next;
    res_new.data_length   = data_bytes_next;
    if (!header_good_next || op.short_file) begin
      res_new.status = STATUS_BAD_HEADER;
    end else if (!format_good_next) begin
      res_new.status = STATUS_NO_FORMAT;
    end else if (!data_seen_next || data_bytes_next == 32'd0) begin
      res_new.status = STATUS_NO_DATA;
    end else if (saved_next[31:16] == 16'd0 || saved_next[63:32] == 32'd0) begin
      res_new.status = STATUS_ZERO_FIELD;
    end else begin
      res_new.status = STATUS_OK;
    end
    if (res_new.status == STATUS_BAD_HEADER) begin
      res_new.channel_count = '0;
      res_new.sample_rate   = '0;
      res_new.byte_rate     = '0;
      res_new.frame_align   = '0;
      res_new.sample_bits   = '0;
      res_new.data_offset   = '0;
      res_new.data_length   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_push) begin
      header_good <= 1'b1;
      pend        <= '0;
      saved       <= '0;
      format_good <= 1'b0;
      data_seen   <= 1'b0;
      data_start  <= '0;
      data_bytes  <= '0;
    end else if (op_pop) begin
      header_good <= header_good_next;
      pend        <= pend_next;
      saved       <= saved_next;
      format_good <= format_good_next;
      data_seen   <= data_seen_next;
      data_start  <= data_start_next;
      data_bytes  <= data_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      rbuf[wptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      rcount <= '0;
    end else begin
      if (res_push) begin
        wptr <= (wptr == RESQ_PTR_BITS'(RESQ_DEPTH - 1)) ? '0 : wptr + RESQ_PTR_BITS'(1);
      end
      if (res_take) begin
        rptr <= (rptr == RESQ_PTR_BITS'(RESQ_DEPTH - 1)) ? '0 : rptr + RESQ_PTR_BITS'(1);
      end
      if (res_push && !res_take) begin
        rcount <= rcount + RESQ_CNT_BITS'(1);
      end else if (res_take && !res_push) begin
        rcount <= rcount - RESQ_CNT_BITS'(1);
      end
    end
  end

endmodule

/* hdl/riff_wave_header_parser_core.sv */
// Top level of the RIFF WAVE header parser: front end, operation queue and back end.
// Throughput is one file word per cycle while full is low; full rises only when the
// four-entry operation queue fills because results are not being popped.
// A result appears on the output ports once the final word has passed the operation queue and the result buffer.
// Synchronous active-high reset empties both queues and returns the parser to the file header.
// After each final word the parser returns to that same state for the next file.
module riff_wave_header_parser_core import rwh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  file_byte,
  input  logic        is_last,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [31:0] byte_rate,
  output logic [15:0] frame_align,
  output logic [15:0] sample_bits,
  output logic [31:0] data_offset,
  output logic [31:0] data_length
);

  op_t     front_op;
  op_t     queue_op;
  logic    queue_empty;
  logic    queue_pop;
  logic    take;
  result_t res;

  assign take = push && !full;

  rwh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .file_byte (file_byte),
    .is_last   (is_last),
    .op        (front_op)
  );

  rwh_op_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .din   (front_op),
    .pop   (queue_pop),
    .dout  (queue_op),
    .empty (queue_empty),
    .full  (full)
  );

  rwh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (!queue_empty),
    .op        (queue_op),
    .op_pop    (queue_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign status        = res.status;
  assign channel_count = res.channel_count;
  assign sample_rate   = res.sample_rate;
  assign byte_rate     = res.byte_rate;
  assign frame_align   = res.frame_align;
  assign sample_bits   = res.sample_bits;
  assign data_offset   = res.data_offset;
  assign data_length   = res.data_length;

endmodule

/* dv/riff_wave_header_parser_core_tb.sv */
// Self-checking testbench for the RIFF WAVE header parser core with a built-in header tracker.
`timescale 1ns / 1ps

module riff_wave_header_parser_core_tb;
  import rwh_pkg::*;

  localparam logic [31:0] RIFF_WORD = "RIFF";
  localparam logic [31:0] WAVE_WORD = "WAVE";
  localparam logic [63:0] POS_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam int CALM_WORDS = 150;

  typedef struct {
    logic [7:0] value;
    bit         last;
    bit         hold;
  } file_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  file_byte = 8'h00;
  logic        is_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] frame_align;
  logic [15:0] sample_bits;
  logic [31:0] data_offset;
  logic [31:0] data_length;

  riff_wave_header_parser_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .file_byte(file_byte),
    .is_last(is_last),
    .empty(empty),
    .pop(pop),
    .status(status),
    .channel_count(channel_count),
    .sample_rate(sample_rate),
    .byte_rate(byte_rate),
    .frame_align(frame_align),
    .sample_bits(sample_bits),
    .data_offset(data_offset),
    .data_length(data_length)
  );

  file_word_t  words_todo[$];
  logic [7:0]  file_buf[$];
  result_t     reports_due[$];
  int          mismatch_count = 0;
  int          send_gap = 0;
  int          pop_stall = 0;
  file_word_t  word_next;

  // Header tracker state.
  logic [63:0] at_offset;
  phase_t      phase;
  bit          header_ok;
  logic [31:0] cur_tag;
  logic [31:0] cur_len;
  logic [63:0] body_end;
  logic [63:0] fmt_stage[2];
  bit          fmt_pcm;
  logic [63:0] fmt_word[2];
  bit          have_data;
  logic [31:0] data_at;
  logic [31:0] data_size;

  function automatic void reset_tracker();
    at_offset = '0;
    phase = PH_FILE;
    header_ok = 1'b1;
    cur_tag = '0;
    cur_len = '0;
    body_end = '0;
    fmt_stage[0] = '0;
    fmt_stage[1] = '0;
    fmt_pcm = 1'b0;
    fmt_word[0] = '0;
    fmt_word[1] = '0;
    have_data = 1'b0;
    data_at = '0;
    data_size = '0;
  endfunction

  function automatic void close_chunk();
    logic [63:0] start;
    start = body_end - {32'd0, cur_len};
    if (cur_tag == TAG_FMT && cur_len >= FMT_MIN) begin
      fmt_word[0] = fmt_stage[0];
      fmt_word[1] = fmt_stage[1];
      fmt_pcm = (fmt_word[0][15:0] == PCM_TAG);
    end else if (cur_tag == TAG_DATA) begin
      have_data = 1'b1;
      data_at = start[31:0];
      data_size = cur_len;
    end
  endfunction

  function automatic void track_byte(input logic [7:0] b, input bit last);
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] size;
    result_t     rep;
    pos = at_offset;
    case (phase)
      PH_FILE: begin
        if (pos < 4 && b != RIFF_WORD[8 * (3 - pos[1:0]) +: 8]) header_ok = 1'b0;
        if (pos >= 8 && pos < 12 && b != WAVE_WORD[8 * (3 - pos[1:0]) +: 8]) header_ok = 1'b0;
        if (pos >= 11) begin
          phase = PH_HEAD;
          body_end = pos + 1;
        end
      end
      PH_HEAD: begin
        idx = pos - body_end;
        if (idx < 4) cur_tag = {b, cur_tag[31:8]};
        else cur_len = {b, cur_len[31:8]};
        if (idx >= 7) begin
          body_end = pos + 1 + {32'd0, cur_len};
          fmt_stage[0] = '0;
          fmt_stage[1] = '0;
          if (cur_len == 0) begin
            close_chunk();
            body_end = pos + 1;
          end else begin
            phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        idx = pos - (body_end - {32'd0, cur_len});
        if (cur_tag == TAG_FMT && idx < 16) fmt_stage[idx[3]][{idx[2:0], 3'b000} +: 8] = b;
        if (pos + 1 == body_end) begin
          close_chunk();
          phase = cur_len[0] ? PH_PAD : PH_HEAD;
        end
      end
      PH_PAD: begin
        body_end = pos + 1;
        phase = PH_HEAD;
      end
      default: ;
    endcase
    size = pos + 1;
    if (at_offset < POS_LIMIT) at_offset = at_offset + 1;
    else phase = PH_HALT;
    if (last) begin
      rep.channel_count = fmt_word[0][31:16];
      rep.sample_rate = fmt_word[0][63:32];
      rep.byte_rate = fmt_word[1][31:0];
      rep.frame_align = fmt_word[1][47:32];
      rep.sample_bits = fmt_word[1][63:48];
      rep.data_offset = data_at;
      rep.data_length = data_size;
      if (!header_ok || size < MIN_FILE_BYTES) rep.status = STATUS_BAD_HEADER;
      else if (!fmt_pcm) rep.status = STATUS_NO_FORMAT;
      else if (!have_data || data_size == 0) rep.status = STATUS_NO_DATA;
      else if (rep.channel_count == 0 || rep.sample_rate == 0) rep.status = STATUS_ZERO_FIELD;
      else rep.status = STATUS_OK;
      if (rep.status == STATUS_BAD_HEADER) begin
        rep = '0;
        rep.status = STATUS_BAD_HEADER;
      end
      reports_due.insert(reports_due.size(), rep);
      reset_tracker();
    end
  endfunction

  // File assembly helpers.
  task automatic put8(input logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endtask

  task automatic put_le(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) file_buf.insert(file_buf.size(), w[8 * i +: 8]);
  endtask

  task automatic put_be32(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_buf.insert(file_buf.size(), w[8 * i +: 8]);
  endtask

  task automatic flush_file(input bit hold);
    file_word_t w;
    for (int i = 0; i < file_buf.size(); i++) begin
      w.value = file_buf[i];
      w.last = (i == file_buf.size() - 1);
      w.hold = hold && (i == 0);
      words_todo.insert(words_todo.size(), w);
    end
    file_buf.delete();
  endtask

  task automatic put_pad(input logic [31:0] len);
    if (len[0]) put8($urandom_range(0, 255));
  endtask

  task automatic put_fmt_chunk();
    logic [31:0] len;
    int          keep;
    int          mark;
    case ($urandom_range(0, 7))
      0: len = 0;
      1: len = 14;
      2: len = 15;
      3: len = 17;
      4: len = 18;
      default: len = 16;
    endcase
    put_le(TAG_FMT, 4);
    put_le(len, 4);
    mark = file_buf.size();
    put_le(($urandom_range(0, 7) == 0) ? $urandom : 32'(PCM_TAG), 2);
    case ($urandom_range(0, 5))
      0: put_le(0, 2);
      1: put_le(32'hFFFF, 2);
      default: put_le($urandom_range(1, 8), 2);
    endcase
    case ($urandom_range(0, 5))
      0: put_le(0, 4);
      1: put_le(32'hFFFF_FFFF, 4);
      default: put_le($urandom, 4);
    endcase
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le($urandom, 2);
    keep = (len < 16) ? len : 16;
    while (file_buf.size() > mark + keep) void'(file_buf.pop_back());
    for (int i = 16; i < len; i++) put8($urandom_range(0, 255));
    put_pad(len);
  endtask

  task automatic put_plain_chunk(input logic [31:0] tag, input logic [31:0] len);
    put_le(tag, 4);
    put_le(len, 4);
    for (int i = 0; i < len; i++) put8($urandom_range(0, 255));
    put_pad(len);
  endtask

  task automatic put_data_chunk();
    logic [31:0] len;
    case ($urandom_range(0, 5))
      0: len = 0;
      1: len = 1;
      default: len = $urandom_range(2, 16);
    endcase
    put_plain_chunk(TAG_DATA, len);
  endtask

  task automatic build_wave();
    put_be32(RIFF_WORD);
    put_le($urandom, 4);
    put_be32(WAVE_WORD);
    if ($urandom_range(0, 2) == 0) put_plain_chunk($urandom, $urandom_range(0, 9));
    if ($urandom_range(0, 9) != 0) put_fmt_chunk();
    if ($urandom_range(0, 5) == 0) put_fmt_chunk();
    if ($urandom_range(0, 3) == 0) put_plain_chunk($urandom, $urandom_range(0, 9));
    if ($urandom_range(0, 9) != 0) put_data_chunk();
    if ($urandom_range(0, 5) == 0) put_data_chunk();
    if ($urandom_range(0, 3) == 0) put_plain_chunk($urandom, $urandom_range(0, 9));
  endtask

  task automatic build_files();
    int total;
    int files;
    int cut;
    int spot;
    // A lone zero word, a lone all-ones word, and a bare RIFF/WAVE header.
    put8(8'h00);
    flush_file(1'b0);
    put8(8'hFF);
    flush_file(1'b0);
    put_be32(RIFF_WORD);
    put_le(32'hFFFF_FFFF, 4);
    put_be32(WAVE_WORD);
    flush_file(1'b0);
    total = 0;
    files = 0;
    while (total < 1250) begin
      case ($urandom_range(0, 9))
        0: begin
          cut = $urandom_range(1, 60);
          for (int i = 0; i < cut; i++) put8($urandom_range(0, 255));
        end
        1: begin
          build_wave();
          spot = $urandom_range(0, 7);
          spot = (spot < 4) ? spot : spot + 4;
          file_buf[spot] = file_buf[spot] ^ (8'd1 << $urandom_range(0, 7));
        end
        2: begin
          build_wave();
          put_le($urandom, 4);
          put_le($urandom | 32'h0001_0000, 4);
          cut = $urandom_range(1, 8);
          for (int i = 0; i < cut; i++) put8($urandom_range(0, 255));
        end
        3: begin
          build_wave();
          cut = $urandom_range(1, file_buf.size());
          while (file_buf.size() > cut) void'(file_buf.pop_back());
        end
        default: build_wave();
      endcase
      total += file_buf.size();
      flush_file(files == 5 || files == 12);
      files++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) track_byte(file_byte, is_last);
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (words_todo.size() != 0 &&
                     !(words_todo[0].hold && reports_due.size() != 0)) begin
          word_next = words_todo[0];
          words_todo.delete(0);
          file_byte <= word_next.value;
          is_last <= word_next.last;
          push <= 1'b1;
          if (words_todo.size() > CALM_WORDS && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(1, 16);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_stall = 0;
    end else begin
      if (pop && !empty) begin
        if (reports_due.size() == 0) begin
          $error("Result word arrived with no file pending: status %0d", status);
          mismatch_count++;
        end else begin
          result_t want;
          want = reports_due[0];
          reports_due.delete(0);
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatch_count++;
          end
          if (channel_count !== want.channel_count) begin
            $error("channel_count: expected %0d, actual %0d", want.channel_count, channel_count);
            mismatch_count++;
          end
          if (sample_rate !== want.sample_rate) begin
            $error("sample_rate: expected %0d, actual %0d", want.sample_rate, sample_rate);
            mismatch_count++;
          end
          if (byte_rate !== want.byte_rate) begin
            $error("byte_rate: expected %0d, actual %0d", want.byte_rate, byte_rate);
            mismatch_count++;
          end
          if (frame_align !== want.frame_align) begin
            $error("frame_align: expected %0d, actual %0d", want.frame_align, frame_align);
            mismatch_count++;
          end
          if (sample_bits !== want.sample_bits) begin
            $error("sample_bits: expected %0d, actual %0d", want.sample_bits, sample_bits);
            mismatch_count++;
          end
          if (data_offset !== want.data_offset) begin
            $error("data_offset: expected %0d, actual %0d", want.data_offset, data_offset);
            mismatch_count++;
          end
          if (data_length !== want.data_length) begin
            $error("data_length: expected %0d, actual %0d", want.data_length, data_length);
            mismatch_count++;
          end
        end
      end
      if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (words_todo.size() > CALM_WORDS && $urandom_range(0, 9) == 0) begin
          pop_stall = $urandom_range(1, 16);
        end
      end
    end
  end

  initial begin
    reset_tracker();
    build_files();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (words_todo.size() != 0 || push || reports_due.size() != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
